>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> hw/rtl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, codes and helpers of the LED matrix bit-plane scan core.
// ----------------------------------------------------------------------------
package lbs_pkg;

	// operation codes carried in s_tuser
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_FILL  = 2'd1;
	localparam logic [1:0] OP_FLIP  = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	// configuration register indexes
	localparam logic [2:0] REG_TOTAL_COLUMNS = 3'd0;
	localparam logic [2:0] REG_PANEL_LINES   = 3'd1;
	localparam logic [2:0] REG_COLOR_DEPTH   = 3'd2;
	localparam logic [2:0] REG_BRIGHTNESS    = 3'd3;
	localparam logic [2:0] REG_DOUBLE_BUFFER = 3'd4;

	localparam int PIX_W = 16;

	// reset values of the registers
	localparam logic [7:0] RST_TOTAL_COLUMNS = 8'd64;
	localparam logic [6:0] RST_PANEL_LINES   = 7'd32;
	localparam logic [3:0] RST_COLOR_DEPTH   = 4'd8;
	localparam logic [7:0] RST_BRIGHTNESS    = 8'd128;

	localparam logic [3:0] MAX_DEPTH = 4'd8;

	// effective (clamped) geometry seen by the datapath
	typedef struct packed {
		logic [7:0] cols;
		logic [6:0] lines;
		logic [5:0] rows;
		logic [3:0] depth;
		logic [7:0] brightness;
		logic       double_buffer;
	} geo_t;

	// panel pins of one scan word
	typedef struct packed {
		logic       red_upper;
		logic       green_upper;
		logic       blue_upper;
		logic       red_lower;
		logic       green_lower;
		logic       blue_lower;
		logic       shift_pulse;
		logic       latch_pulse;
		logic [4:0] row_address;
		logic       output_disable;
	} pins_t;

	// RGB565 -> RGB888, low bits zero
	function automatic logic [23:0] expand565(input logic [15:0] c);
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		r = {c[15:11], 3'b000};
		g = {c[10:5], 2'b00};
		b = {c[4:0], 3'b000};
		return {r, g, b};
	endfunction

endpackage

>>> hw/rtl/lbs_frame_ram.sv
// ----------------------------------------------------------------------------
// lbs_frame_ram
// Frame store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module lbs_frame_ram #(
	parameter int ADDR_W = 14,
	parameter int DATA_W = 16
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

>>> hw/rtl/lbs_draw_ctl.sv
// ----------------------------------------------------------------------------
// lbs_draw_ctl
// Write side of the frame store: pixel writes, fill sweep, post-reset clear
// sweep and bank selection.
// ----------------------------------------------------------------------------
module lbs_draw_ctl #(
	parameter int COL_W  = 7,
	parameter int LINE_W = 6,
	parameter int ADDR_W = 14
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  logic [1:0]          operation,
	input  logic signed [15:0]  pixel_x,
	input  logic signed [15:0]  pixel_y,
	input  logic [15:0]         pixel_color,
	input  lbs_pkg::geo_t       geo,
	output logic                busy,
	output logic                show_bank,
	output logic                we,
	output logic [ADDR_W-1:0]   waddr,
	output logic [15:0]         wdata
);
	import lbs_pkg::*;

	logic              back_bank_q;
	logic              clearing_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              filling_q;
	logic [7:0]        fill_x_q;
	logic [6:0]        fill_y_q;
	logic [7:0]        fill_last_x_q;
	logic [6:0]        fill_last_y_q;
	logic              fill_bank_q;
	logic [15:0]       fill_color_q;

	logic draw_bank;
	logic pix_ok;
	logic fill_done;

	assign draw_bank = geo.double_buffer & back_bank_q;
	assign show_bank = geo.double_buffer & ~back_bank_q;
	assign busy      = clearing_q | filling_q;

	assign pix_ok = !pixel_x[15] && !pixel_y[15]
		&& ($unsigned(pixel_x) < {8'd0, geo.cols})
		&& ($unsigned(pixel_y) < {9'd0, geo.lines});

	assign fill_done = (fill_x_q == fill_last_x_q) && (fill_y_q == fill_last_y_q);

	// write port mux: clear sweep, fill sweep, then single pixel
	always_comb begin
		if (clearing_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else if (filling_q) begin
			we    = 1'b1;
			waddr = {fill_bank_q, LINE_W'(fill_y_q), COL_W'(fill_x_q)};
			wdata = fill_color_q;
		end else begin
			we    = go && (operation == OP_WRITE) && pix_ok;
			waddr = {draw_bank, LINE_W'($unsigned(pixel_y)), COL_W'($unsigned(pixel_x))};
			wdata = pixel_color;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_bank_q <= 1'b0;
			clearing_q  <= 1'b1;
			clr_addr_q  <= '0;
			filling_q   <= 1'b0;
			fill_x_q    <= '0;
			fill_y_q    <= '0;
		end else begin
			if (clearing_q) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				if (&clr_addr_q) begin
					clearing_q <= 1'b0;
				end
			end
			if (filling_q) begin
				if (fill_done) begin
					filling_q <= 1'b0;
				end else if (fill_x_q == fill_last_x_q) begin
					fill_x_q <= '0;
					fill_y_q <= fill_y_q + 7'd1;
				end else begin
					fill_x_q <= fill_x_q + 8'd1;
				end
			end
			if (go && (operation == OP_FILL)) begin
				filling_q <= 1'b1;
				fill_x_q  <= '0;
				fill_y_q  <= '0;
			end
			if (go && (operation == OP_FLIP) && geo.double_buffer) begin
				back_bank_q <= ~back_bank_q;
			end
		end
	end

	// fill payload, captured at start
	always_ff @(posedge clk) begin
		if (go && (operation == OP_FILL)) begin
			fill_last_x_q <= geo.cols - 8'd1;
			fill_last_y_q <= geo.lines - 7'd1;
			fill_bank_q   <= draw_bank;
			fill_color_q  <= pixel_color;
		end
	end

endmodule

>>> hw/rtl/lbs_scan_seq.sv
// ----------------------------------------------------------------------------
// lbs_scan_seq
// Scan sequencer: shift / latch / display phases, frame store read request
// and panel pin formation from the read data.
// ----------------------------------------------------------------------------
module lbs_scan_seq #(
	parameter int MAX_LINES = 64,
	parameter int COL_W     = 7,
	parameter int LINE_W    = 6,
	parameter int ADDR_W    = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              tick_go,
	input  lbs_pkg::geo_t     geo,
	input  logic              show_bank,
	output logic              re,
	output logic [ADDR_W-1:0] raddr_up,
	output logic [ADDR_W-1:0] raddr_lo,
	input  logic [15:0]       rdata_up,
	input  logic [15:0]       rdata_lo,
	output lbs_pkg::pins_t    pins
);
	import lbs_pkg::*;

	typedef enum logic [1:0] {
		PH_SHIFT = 2'd0,
		PH_LATCH = 2'd1,
		PH_SHOW  = 2'd2
	} phase_t;

	typedef struct packed {
		logic       shift_pulse;
		logic       latch_pulse;
		logic [4:0] row_address;
		logic       output_disable;
		logic [2:0] bit_idx;
		logic       show_up;
		logic       show_lo;
	} info_t;

	phase_t     phase_q, phase_d;
	logic [4:0] row_q, row_d;
	logic [2:0] plane_q, plane_d;
	logic [7:0] col_q, col_d;
	logic [7:0] dc_q, dc_d;
	logic [4:0] held_q, held_d;
	info_t      info_s1, info_d;

	logic [15:0] prod;
	logic [16:0] quot;
	logic [7:0]  active;
	logic [7:0]  span;
	logic [7:0]  dc_inc;
	logic [2:0]  plane_inc;
	logic [4:0]  row_inc;
	logic [8:0]  col_inc;
	logic [6:0]  lower_line;
	logic [3:0]  bit_sum;
	logic        plane_ok;

	always_comb begin
		phase_d = phase_q;
		row_d   = row_q;
		plane_d = plane_q;
		col_d   = col_q;
		dc_d    = dc_q;
		held_d  = held_q;
		info_d  = '0;
		info_d.output_disable = 1'b1;

		// brightness * 2^plane / 255, exact below 65535
		prod       = {8'd0, geo.brightness} << plane_q;
		quot       = {1'b0, prod} + 17'd1 + {9'd0, prod[15:8]};
		active     = quot[15:8];
		span       = 8'd1 << plane_q;
		dc_inc     = dc_q + 8'd1;
		plane_inc  = plane_q + 3'd1;
		row_inc    = row_q + 5'd1;
		col_inc    = {1'b0, col_q} + 9'd1;
		lower_line = {2'b00, row_q} + {1'b0, geo.rows};
		bit_sum    = MAX_DEPTH - geo.depth + {1'b0, plane_q};
		plane_ok   = ({1'b0, plane_q} < geo.depth);

		case (phase_q)
			PH_LATCH: begin
				held_d             = row_q;
				info_d.latch_pulse = 1'b1;
				dc_d               = '0;
				phase_d            = PH_SHOW;
			end
			PH_SHOW: begin
				if (dc_q < active) begin
					info_d.output_disable = 1'b0;
				end
				dc_d = dc_inc;
				if (dc_inc >= span) begin
					dc_d    = '0;
					col_d   = '0;
					phase_d = PH_SHIFT;
					if (({1'b0, plane_inc} >= geo.depth) || (plane_inc == 3'd0)) begin
						plane_d = '0;
						if (({1'b0, row_inc} >= geo.rows) || (row_inc == 5'd0)) begin
							row_d = '0;
						end else begin
							row_d = row_inc;
						end
					end else begin
						plane_d = plane_inc;
					end
				end
			end
			default: begin
				// shift phase; the spare code behaves the same
				info_d.shift_pulse = 1'b1;
				if (plane_ok && (col_q < geo.cols)) begin
					info_d.show_up = (32'(row_q) < MAX_LINES);
					info_d.show_lo = (32'(lower_line) < MAX_LINES);
				end
				if (col_inc >= {1'b0, geo.cols}) begin
					col_d   = '0;
					phase_d = PH_LATCH;
				end else begin
					col_d = col_inc[7:0];
				end
			end
		endcase

		info_d.row_address = held_d;
		info_d.bit_idx     = bit_sum[2:0];
	end

	assign re       = tick_go;
	assign raddr_up = {show_bank, LINE_W'(row_q), COL_W'(col_q)};
	assign raddr_lo = {show_bank, LINE_W'(lower_line), COL_W'(col_q)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SHIFT;
			row_q   <= '0;
			plane_q <= '0;
			col_q   <= '0;
			dc_q    <= '0;
			held_q  <= '0;
			info_s1 <= '0;
		end else if (tick_go) begin
			phase_q <= phase_d;
			row_q   <= row_d;
			plane_q <= plane_d;
			col_q   <= col_d;
			dc_q    <= dc_d;
			held_q  <= held_d;
			info_s1 <= info_d;
		end
	end

	// pick the plane bit out of the registered read data
	logic [23:0] up_rgb;
	logic [23:0] lo_rgb;

	always_comb begin
		up_rgb = expand565(rdata_up);
		lo_rgb = expand565(rdata_lo);
		pins.red_upper      = info_s1.show_up & up_rgb[16 + {2'b00, info_s1.bit_idx}];
		pins.green_upper    = info_s1.show_up & up_rgb[8 + {2'b00, info_s1.bit_idx}];
		pins.blue_upper     = info_s1.show_up & up_rgb[{2'b00, info_s1.bit_idx}];
		pins.red_lower      = info_s1.show_lo & lo_rgb[16 + {2'b00, info_s1.bit_idx}];
		pins.green_lower    = info_s1.show_lo & lo_rgb[8 + {2'b00, info_s1.bit_idx}];
		pins.blue_lower     = info_s1.show_lo & lo_rgb[{2'b00, info_s1.bit_idx}];
		pins.shift_pulse    = info_s1.shift_pulse;
		pins.latch_pulse    = info_s1.latch_pulse;
		pins.row_address    = info_s1.row_address;
		pins.output_disable = info_s1.output_disable;
	end

endmodule

>>> hw/rtl/led_matrix_bitplane_scan_core.sv
// ----------------------------------------------------------------------------
// led_matrix_bitplane_scan_core
// Two-bank RGB565 frame store with a bit-plane (BCM) panel scan engine.
// ----------------------------------------------------------------------------
// Usage:
//  - Input stream s_*: s_tuser is the operation (write pixel, fill, flip,
//    scan tick), s_tdata carries x, y and the RGB565 color.
//  - Output stream m_*: one word per scan tick, none for other operations.
//    Each word is the panel pin state for that tick (color bits, shift and
//    latch pulses, row select, output disable).
//  - Config port cfg_*: one register per write, taken at any edge with
//    cfg_we high; write only while the block is idle.
//  - An accepted scan tick passes the read stage, then the output register.
//  - Throughput: one item per clock while the receiver keeps up and no
//    sweep runs; the frame store read (two ports, registered) keeps pace.
//  - Fill sweeps lines*columns store entries, one per clock, with s_tready
//    low meanwhile.
//  - Reset: the store is cleared by a sweep over all 2*2^(LINE_W+COL_W) entries
//    (16384 at the default sizes) before s_tready rises; config registers
//    load their defaults at once.
//  - Stall: with m_tready low, one word waits in the output register and one
//    more in the read stage, then s_tready drops until the output drains.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module led_matrix_bitplane_scan_core #(
	parameter int MAX_COLUMNS = 128,
	parameter int MAX_LINES   = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [15:0] pixel_x, [31:16] pixel_y, [47:32] pixel_color
	input  logic [1:0]  s_tuser,   // [1:0] operation
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] red_upper, [1] green_upper, [2] blue_upper,
	                               // [3] red_lower, [4] green_lower, [5] blue_lower,
	                               // [6] shift_pulse, [7] latch_pulse,
	                               // [12:8] row_address, [13] output_disable, [15:14] zero
	// config write port
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [7:0]  cfg_wdata
);
	import lbs_pkg::*;

	localparam int COL_W  = $clog2(MAX_COLUMNS);
	localparam int LINE_W = (MAX_LINES > 2) ? $clog2(MAX_LINES) : 1;
	localparam int ADDR_W = 1 + LINE_W + COL_W;

	// clamp limits for the effective geometry
	localparam logic [7:0] COLS_CAP  = (MAX_COLUMNS > 255) ? 8'd255 : 8'(MAX_COLUMNS);
	localparam logic [6:0] LINES_CAP = 7'(MAX_LINES - (MAX_LINES % 2));

	// ---------------- config registers ----------------
	logic [7:0] total_columns_q;
	logic [6:0] panel_lines_q;
	logic [3:0] color_depth_q;
	logic [7:0] brightness_q;
	logic       double_buffer_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_columns_q <= RST_TOTAL_COLUMNS;
			panel_lines_q   <= RST_PANEL_LINES;
			color_depth_q   <= RST_COLOR_DEPTH;
			brightness_q    <= RST_BRIGHTNESS;
			double_buffer_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_TOTAL_COLUMNS: total_columns_q <= cfg_wdata;
				REG_PANEL_LINES:   panel_lines_q   <= cfg_wdata[6:0];
				REG_COLOR_DEPTH:   color_depth_q   <= cfg_wdata[3:0];
				REG_BRIGHTNESS:    brightness_q    <= cfg_wdata;
				REG_DOUBLE_BUFFER: double_buffer_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// effective geometry: zero widths act as minimum, oversize saturates
	geo_t       geo;
	logic [6:0] lines_even;

	always_comb begin
		lines_even = {panel_lines_q[6:1], 1'b0};
		if (total_columns_q == 8'd0) begin
			geo.cols = 8'd1;
		end else if (total_columns_q > COLS_CAP) begin
			geo.cols = COLS_CAP;
		end else begin
			geo.cols = total_columns_q;
		end
		if (lines_even < 7'd2) begin
			geo.lines = 7'd2;
		end else if (lines_even > LINES_CAP) begin
			geo.lines = LINES_CAP;
		end else begin
			geo.lines = lines_even;
		end
		geo.rows = geo.lines[6:1];
		if (color_depth_q == 4'd0) begin
			geo.depth = 4'd1;
		end else if (color_depth_q > MAX_DEPTH) begin
			geo.depth = MAX_DEPTH;
		end else begin
			geo.depth = color_depth_q;
		end
		geo.brightness    = brightness_q;
		geo.double_buffer = double_buffer_q;
	end

	// ---------------- handshake ----------------
	logic  busy;
	logic  valid_s1;
	logic  out_free;
	logic  accept;
	logic  tick_go;
	logic  move;
	logic  m_valid_q;
	pins_t pins;
	pins_t out_q;

	assign out_free = !m_valid_q || m_tready;
	assign move     = valid_s1 && out_free;
	assign s_tready = !busy && (!valid_s1 || out_free);
	assign accept   = s_tvalid && s_tready;
	assign tick_go  = accept && (s_tuser == OP_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (tick_go) begin
				valid_s1 <= 1'b1;
			end else if (move) begin
				valid_s1 <= 1'b0;
			end
			if (move) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q <= pins;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {2'b00, out_q.output_disable, out_q.row_address,
		out_q.latch_pulse, out_q.shift_pulse,
		out_q.blue_lower, out_q.green_lower, out_q.red_lower,
		out_q.blue_upper, out_q.green_upper, out_q.red_upper};

	// ---------------- frame store and its two clients ----------------
	logic              show_bank;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [15:0]       wr_data;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr_up;
	logic [ADDR_W-1:0] rd_addr_lo;
	logic [15:0]       rd_data_up;
	logic [15:0]       rd_data_lo;

	lbs_draw_ctl #(
		.COL_W  (COL_W),
		.LINE_W (LINE_W),
		.ADDR_W (ADDR_W)
	) u_draw (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (accept),
		.operation   (s_tuser),
		.pixel_x     (s_tdata[15:0]),
		.pixel_y     (s_tdata[31:16]),
		.pixel_color (s_tdata[47:32]),
		.geo         (geo),
		.busy        (busy),
		.show_bank   (show_bank),
		.we          (wr_en),
		.waddr       (wr_addr),
		.wdata       (wr_data)
	);

	lbs_scan_seq #(
		.MAX_LINES (MAX_LINES),
		.COL_W     (COL_W),
		.LINE_W    (LINE_W),
		.ADDR_W    (ADDR_W)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.tick_go   (tick_go),
		.geo       (geo),
		.show_bank (show_bank),
		.re        (rd_en),
		.raddr_up  (rd_addr_up),
		.raddr_lo  (rd_addr_lo),
		.rdata_up  (rd_data_up),
		.rdata_lo  (rd_data_lo),
		.pins      (pins)
	);

	lbs_frame_ram #(
		.ADDR_W (ADDR_W),
		.DATA_W (PIX_W)
	) u_ram (
		.clk     (clk),
		.we      (wr_en),
		.waddr   (wr_addr),
		.wdata   (wr_data),
		.re      (rd_en),
		.raddr_a (rd_addr_up),
		.raddr_b (rd_addr_lo),
		.rdata_a (rd_data_up),
		.rdata_b (rd_data_lo)
	);

	// ---------------- assertions ----------------
	// a scan read never shares a cycle with a store write
	`ASSERT_IMPLIES(a_no_rd_wr_overlap, clk, arst_n, rd_en, !wr_en)
	// an accepted tick always lands in the read stage
	`ASSERT_NEXT(a_tick_to_s1, clk, arst_n, tick_go, valid_s1)
	// latch words are blanked and never shift
	`ASSERT_IMPLIES(a_latch_blank, clk, arst_n, m_valid_q && out_q.latch_pulse,
		out_q.output_disable && !out_q.shift_pulse)
	// shift words are blanked
	`ASSERT_IMPLIES(a_shift_blank, clk, arst_n, m_valid_q && out_q.shift_pulse,
		out_q.output_disable)

endmodule
